// ----- rtl/core/tss_pkg.sv -----
package tss_pkg;

  localparam int FUNC_W   = 2;
  localparam int BUD_IN_W = 16;
  localparam int TID_O_W  = 4;
  localparam int STAT_W   = 2;
  localparam int QUANT_W  = 8;

  localparam logic [QUANT_W-1:0] QUANT_RESET = 8'd20;

  localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EXIT   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

  localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_HALT = 2'd2;

endpackage

// ----- rtl/core/tss_if.sv -----
interface tss_req_if;
  import tss_pkg::*;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic                priority_req;
  logic [BUD_IN_W-1:0] budget_ticks;

  modport source (output valid, func, priority_req, budget_ticks, input ready);
  modport sink   (input valid, func, priority_req, budget_ticks, output ready);
endinterface

interface tss_rsp_if;
  import tss_pkg::*;
  logic               valid;
  logic               ready;
  logic [TID_O_W-1:0] running_tid;
  logic [TID_O_W-1:0] created_tid;
  logic [STAT_W-1:0]  status;
  logic               switched;

  modport source (output valid, running_tid, created_tid, status, switched, input ready);
  modport sink   (input valid, running_tid, created_tid, status, switched, output ready);
endinterface

// ----- rtl/core/two_level_sjf_rr_thread_scheduler.sv -----
// Flow, accept to result valid: a no-op or a halted block answers directly; exit runs a pick;
// tick reads the runner's slot and runs a pick when the thread leaves or its slice expires;
// create scans for a free slot from 1 up, and a high create adds a compare and an insert walk.
// The block takes one item at a time; the next item is accepted in the cycle after the result
// loads. The preemption check and the insert walk share one compare unit.
// Reset (rst, synchronous): slot 0 runs, queues empty, quantum 20; no clearing pass.
module two_level_sjf_rr_thread_scheduler #(
  parameter int MAX_THREADS = 16,
  parameter int BUDGET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   quantum_we,
  input  logic [tss_pkg::QUANT_W-1:0] quantum_wdata,
  tss_req_if.sink                req,
  tss_rsp_if.source              rsp
);
  import tss_pkg::*;

  localparam int TID_W = $clog2(MAX_THREADS);
  localparam int CNT_W = $clog2(MAX_THREADS + 1);
  localparam int QDEP  = 1 << TID_W;
  localparam int SW    = QUANT_W + BUDGET_BITS;
  localparam int HW    = BUDGET_BITS + TID_W;
  localparam logic [TID_W-1:0] LAST_TID = TID_W'(MAX_THREADS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_CR_RD, S_CR_CMP, S_TK_RD, S_TK_EXE,
    S_PK_ISSUE, S_PK_DATA, S_INS_RD, S_INS_CMP, S_DONE
  } state_t;

  state_t state;

  logic [QUANT_W-1:0]     quantum;
  logic [MAX_THREADS-1:0] busy, high, vld;
  logic [CNT_W-1:0]       lcount, hcount, j;
  logic [TID_W-1:0]       lhead, hhead, current, prev_tid, idx, created;
  logic                   halted, hi_req, sel_high;
  logic [BUDGET_BITS-1:0] bud_req, ins_key;
  logic [TID_W-1:0]       ins_tid;
  logic [STAT_W-1:0]      st;
  logic                   rd_vld;

  logic                   rsp_valid, rsp_switched, rsp_load;
  logic [TID_O_W-1:0]     rsp_running, rsp_created;
  logic [STAT_W-1:0]      rsp_status;

  // memory ports
  logic             s_we, f_we, h_we;
  logic [TID_W-1:0] s_waddr, f_waddr, h_waddr, h_raddr;
  logic [SW-1:0]    s_wdata, s_rdata;
  logic [TID_W-1:0] f_rdata;
  logic [HW-1:0]    h_wdata, h_rdata;

  logic [QUANT_W-1:0]     q_eff, rd_slice, new_slice;
  logic [BUDGET_BITS-1:0] rd_budget, new_budget, h_rkey;
  logic                   gone, expire, lpush;
  logic [BUDGET_BITS-1:0] cmp_a, cmp_b;
  logic                   cmp_lt;

  assign q_eff     = (quantum == '0) ? QUANT_W'(1) : quantum;
  assign rd_budget = rd_vld ? s_rdata[BUDGET_BITS-1:0] : '0;
  assign rd_slice  = rd_vld ? s_rdata[SW-1:BUDGET_BITS] : QUANT_RESET;
  assign h_rkey    = h_rdata[HW-1:TID_W];

  // shared compare: new budget against runner, or new key against queue entry
  assign cmp_a  = (state == S_INS_CMP) ? ins_key : bud_req;
  assign cmp_b  = (state == S_INS_CMP) ? h_rkey : rd_budget;
  assign cmp_lt = cmp_a < cmp_b;

  always_comb begin
    new_budget = rd_budget;
    if (current != '0 && rd_budget != '0) begin
      new_budget = rd_budget - BUDGET_BITS'(1);
    end
    gone   = (current != '0) && (new_budget == '0);
    expire = !gone && !high[current] && (rd_slice <= QUANT_W'(1));
    if (high[current]) begin
      new_slice = rd_slice;
    end else if (expire) begin
      new_slice = q_eff;
    end else begin
      new_slice = rd_slice - QUANT_W'(1);
    end
  end

  always_comb begin
    s_we    = 1'b0;
    s_waddr = idx;
    s_wdata = {q_eff, bud_req};
    lpush   = 1'b0;
    f_waddr = lhead + lcount[TID_W-1:0];
    f_we    = 1'b0;
    h_we    = 1'b0;
    h_waddr = hhead + j[TID_W-1:0];
    h_wdata = {ins_key, ins_tid};
    h_raddr = (state == S_INS_RD) ? hhead + j[TID_W-1:0] - TID_W'(1) : hhead;
    case (state)
      S_FIND: begin
        if (!busy[idx]) begin
          s_we  = 1'b1;
          lpush = !hi_req;
        end
      end
      S_TK_EXE: begin
        s_we    = !gone;
        s_waddr = current;
        s_wdata = {new_slice, new_budget};
        lpush   = expire;
      end
      S_INS_RD: begin
        h_we = (j == '0);
      end
      S_INS_CMP: begin
        h_we = 1'b1;
        if (cmp_lt) begin
          h_wdata = h_rdata;
        end
      end
      default: ;
    endcase
    f_we = lpush && (lcount < CNT_W'(MAX_THREADS));
  end

  tss_ram #(.WIDTH(SW), .DEPTH(MAX_THREADS)) u_slot (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(current), .rdata(s_rdata)
  );

  tss_ram #(.WIDTH(TID_W), .DEPTH(QDEP)) u_low (
    .clk, .we(f_we), .waddr(f_waddr), .wdata(state == S_FIND ? idx : current),
    .raddr(lhead), .rdata(f_rdata)
  );

  tss_ram #(.WIDTH(HW), .DEPTH(QDEP)) u_high (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
  );

  assign req.ready = (state == S_IDLE);
  assign rsp_load  = (state == S_DONE) && (!rsp_valid || rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      quantum   <= QUANT_RESET;
      busy      <= MAX_THREADS'(1);
      high      <= '0;
      vld       <= '0;
      lcount    <= '0;
      hcount    <= '0;
      lhead     <= '0;
      hhead     <= '0;
      current   <= '0;
      halted    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (quantum_we) begin
        quantum <= quantum_wdata;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      rd_vld <= vld[current];
      if (f_we) begin
        lcount <= lcount + CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            prev_tid <= current;
            created  <= '0;
            st       <= STATUS_OK;
            hi_req   <= req.priority_req;
            bud_req  <= BUDGET_BITS'(req.budget_ticks);
            idx      <= TID_W'(1);
            if (halted) begin
              st    <= STATUS_HALT;
              state <= S_DONE;
            end else begin
              case (req.func)
                FUNC_CREATE: state <= S_FIND;
                FUNC_TICK:   state <= S_TK_RD;
                FUNC_EXIT: begin
                  busy[current] <= 1'b0;
                  high[current] <= 1'b0;
                  vld[current]  <= 1'b0;
                  state         <= S_PK_ISSUE;
                end
                default:     state <= S_DONE;
              endcase
            end
          end
        end
        S_FIND: begin
          if (!busy[idx]) begin
            created   <= idx;
            busy[idx] <= 1'b1;
            high[idx] <= hi_req;
            vld[idx]  <= 1'b1;
            state     <= hi_req ? S_CR_RD : S_DONE;
          end else if (idx == LAST_TID) begin
            st    <= STATUS_FULL;
            state <= S_DONE;
          end else begin
            idx <= idx + TID_W'(1);
          end
        end
        S_CR_RD: state <= S_CR_CMP;
        S_CR_CMP: begin
          // a shorter budget takes the processor; the runner waits sorted
          if (cmp_lt) begin
            ins_key <= rd_budget;
            ins_tid <= current;
            current <= created;
          end else begin
            ins_key <= bud_req;
            ins_tid <= created;
          end
          j     <= hcount;
          state <= (hcount < CNT_W'(MAX_THREADS)) ? S_INS_RD : S_DONE;
        end
        S_INS_RD: begin
          if (j == '0) begin
            hcount <= hcount + CNT_W'(1);
            state  <= S_DONE;
          end else begin
            state <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (cmp_lt) begin
            j     <= j - CNT_W'(1);
            state <= S_INS_RD;
          end else begin
            hcount <= hcount + CNT_W'(1);
            state  <= S_DONE;
          end
        end
        S_TK_RD: state <= S_TK_EXE;
        S_TK_EXE: begin
          if (gone) begin
            busy[current] <= 1'b0;
            high[current] <= 1'b0;
            vld[current]  <= 1'b0;
            state         <= S_PK_ISSUE;
          end else begin
            vld[current] <= 1'b1;
            state        <= expire ? S_PK_ISSUE : S_DONE;
          end
        end
        S_PK_ISSUE: begin
          if (hcount != '0) begin
            sel_high <= 1'b1;
            state    <= S_PK_DATA;
          end else if (lcount != '0) begin
            sel_high <= 1'b0;
            state    <= S_PK_DATA;
          end else begin
            halted <= 1'b1;
            st     <= STATUS_HALT;
            state  <= S_DONE;
          end
        end
        S_PK_DATA: begin
          if (sel_high) begin
            current <= h_rdata[TID_W-1:0];
            hhead   <= hhead + TID_W'(1);
            hcount  <= hcount - CNT_W'(1);
          end else begin
            current <= f_rdata;
            lhead   <= lhead + TID_W'(1);
            lcount  <= lcount - CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (rsp_load) begin
            rsp_running  <= TID_O_W'(current);
            rsp_created  <= (st == STATUS_OK) ? TID_O_W'(created) : '0;
            rsp_status   <= st;
            rsp_switched <= (st != STATUS_HALT) && (current != prev_tid);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.running_tid = rsp_running;
  assign rsp.created_tid = rsp_created;
  assign rsp.status      = rsp_status;
  assign rsp.switched    = rsp_switched;

`ifndef SYNTHESIS
  a_queue_total: assert property (@(posedge clk) disable iff (rst)
    (CNT_W + 1)'(lcount) + (CNT_W + 1)'(hcount) <= (CNT_W + 1)'(MAX_THREADS))
    else $error("ready queues hold more entries than slots");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted cleared without reset");
  a_full_no_tid: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STATUS_FULL) |-> (rsp.created_tid == '0 && !rsp.switched))
    else $error("failed create reports a slot or a switch");
`endif

endmodule

// ----- rtl/core/tss_ram.sv -----
module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
